FILE: sv/lane_window_center_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// Lane window center tracker assertion macros
// Shared property forms for the concurrent checks of the tracker.
// ----------------------------------------------------------------------------
`ifndef LANE_WINDOW_CENTER_TRACKER_UNIT_DEFINES_SVH
`define LANE_WINDOW_CENTER_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define LWCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwct assertion failed");

// Next-cycle implication, disabled while reset is active.
`define LWCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwct assertion failed");

`endif

FILE: sv/lwct_pkg.sv
// ----------------------------------------------------------------------------
// Lane window center tracker package
// Word types, register map and reset values shared by the tracker.
// ----------------------------------------------------------------------------
package lwct_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel;
    } t_in;

    typedef struct packed {
        logic       detected;
        logic [9:0] left_edge_x;
        logic [9:0] right_edge_x;
        logic [9:0] center_x;
        logic [9:0] next_window_left_x;
    } t_out;

    localparam int ADDR_W = 4;
    localparam int SW     = 16;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_THRESHOLD = 2'd0;
    localparam t_reg_idx REG_WIDTH     = 2'd1;
    localparam t_reg_idx REG_HOME      = 2'd2;

    localparam logic [7:0] RST_THRESHOLD = 8'd128;
    localparam logic [7:0] RST_WIDTH     = 8'd64;
    localparam logic [9:0] RST_HOME      = 10'd320;

endpackage

FILE: sv/lane_window_center_tracker_unit.sv
// ----------------------------------------------------------------------------
// Lane window center tracker
// Accumulates window columns in a memory, scans them for bright columns and
// moves the window center to the midpoint of the lane.
// ----------------------------------------------------------------------------
// Pixel and reset-action words are taken one per cycle while busy is low. After
// the last pixel of a window busy stays high while the column scan reads the
// w entries of the effective window width, one per cycle through the single
// read port, and then states S_FIN1 and S_FIN2 finish the center update.
// The result word is shown for one cycle right as busy falls, and the
// receiver cannot stall it. A write to window_width while idle, with no word
// taken alongside it, raises busy while the remainder unit recomputes the
// current column.
`include "lane_window_center_tracker_unit_defines.svh"

module lane_window_center_tracker_unit #(
    parameter int FRAME_WIDTH      = 640,
    parameter int WINDOW_ROWS      = 16,
    parameter int MAX_WINDOW_WIDTH = 128,
    parameter int BOUND_WIDTH      = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lwct_pkg::t_in              i_in,
    output logic                       o_result_valid,
    output lwct_pkg::t_out             o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lwct_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import lwct_pkg::*;

    localparam int AW       = $clog2(MAX_WINDOW_WIDTH);
    localparam int WW_W     = $clog2(MAX_WINDOW_WIDTH + 1);
    localparam int WMAX     = (MAX_WINDOW_WIDTH / 2) * 2;
    localparam int PW       = $clog2(MAX_WINDOW_WIDTH * WINDOW_ROWS + 1);
    localparam int SUM_W    = $clog2(255 * MAX_WINDOW_WIDTH * WINDOW_ROWS + 1);
    localparam int CMP_W    = SUM_W + 1;
    localparam int BOUND_LO = BOUND_WIDTH / 2;
    localparam int HI_RAW   = FRAME_WIDTH - 1 - BOUND_WIDTH;
    localparam int BOUND_HI = (HI_RAW < BOUND_LO) ? BOUND_LO : HI_RAW;

    localparam logic signed [SW-1:0] C_LO     = SW'(BOUND_LO);
    localparam logic signed [SW-1:0] C_HI     = SW'(BOUND_HI);
    localparam logic signed [SW-1:0] C_FW_MAX = SW'(FRAME_WIDTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REM_GO = 3'd1;
    localparam logic [2:0] S_REM    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FIN1   = 3'd4;
    localparam logic [2:0] S_FIN2   = 3'd5;

    function automatic logic [WW_W-1:0] f_eff(input logic [7:0] ww);
        logic [9:0] wv;
        wv = {2'b00, ww[7:1], 1'b0};
        if (wv < 10'd2) begin
            wv = 10'd2;
        end
        if (wv > 10'(WMAX)) begin
            wv = 10'(WMAX);
        end
        return wv[WW_W-1:0];
    endfunction

    logic [7:0]              r_threshold;
    logic [7:0]              r_width;
    logic [9:0]              r_home;
    logic [2:0]              r_state;
    logic [PW-1:0]           r_pos;
    logic [AW-1:0]           r_col;
    logic [PW-1:0]           r_total;
    logic [CMP_W-1:0]        r_lim;
    logic [9:0]              r_center;
    logic [9:0]              r_left;
    logic [9:0]              r_right;
    logic                    r_p1_vld;
    logic [AW-1:0]           r_p1_addr;
    logic [7:0]              r_p1_pix;
    logic [WW_W-1:0]         r_scan_idx;
    logic                    r_cmp_vld;
    logic [AW-1:0]           r_cmp_idx;
    logic                    r_found;
    logic [AW-1:0]           r_first;
    logic [AW-1:0]           r_last;
    logic signed [SW-1:0]    r_mid;
    logic                    r_out_vld;
    t_out                    r_out;

    logic [WW_W-1:0]         w;
    logic [WW_W-1:0]         half;
    logic                    cfg_wr;
    t_reg_idx                cfg_idx;
    logic                    acc;
    logic                    acc_pix;
    logic                    acc_act;
    logic [PW-1:0]           n_pos;
    logic                    win_end;
    logic                    col_last;
    logic                    scan_rd;
    logic                    scan_last;
    logic                    bright;
    logic [PW-1:0]           n_total;
    logic [CMP_W-1:0]        n_lim;
    logic                    mem_clr;
    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    logic [SUM_W-1:0]        mem_rd_data;
    logic [SUM_W-1:0]        mem_wr_data;
    logic                    rem_done;
    logic [AW-1:0]           rem_val;
    logic signed [SW-1:0]    c_center;
    logic signed [SW-1:0]    c_half;
    logic signed [SW-1:0]    c_l;
    logic signed [SW-1:0]    c_r;
    logic signed [SW-1:0]    c_s;
    logic signed [SW-1:0]    n_mid;
    logic [9:0]              n_left;
    logic [9:0]              n_right;
    logic signed [SW-1:0]    clamped;
    logic                    clamp_hit;
    logic [9:0]              n_center;
    logic signed [SW-1:0]    c_lnw;
    t_out                    n_out;

    assign w        = f_eff(r_width);
    assign half     = w >> 1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[3:2];
    assign acc      = start && !busy;
    assign acc_pix  = acc && !i_in.action;
    assign acc_act  = acc && i_in.action;
    assign n_pos    = r_pos + PW'(1);
    assign win_end  = n_pos >= r_total;
    assign col_last = (WW_W'(r_col) + WW_W'(1)) == w;
    assign scan_rd  = (r_state == S_SCAN) && (r_scan_idx < w);
    assign scan_last = r_cmp_vld && ((WW_W'(r_cmp_idx) + WW_W'(1)) == w);
    assign bright   = (CMP_W'(mem_rd_data) + CMP_W'(WINDOW_ROWS / 2)) >= r_lim;
    assign n_total  = PW'(int'(w) * WINDOW_ROWS);
    assign n_lim    = CMP_W'((int'(r_threshold) + 1) * WINDOW_ROWS);

    assign mem_clr     = acc_act || (r_state == S_FIN2);
    assign mem_rd_en   = acc_pix || scan_rd;
    assign mem_rd_addr = acc_pix ? r_col : r_scan_idx[AW-1:0];
    assign mem_wr_data = mem_rd_data + SUM_W'(r_p1_pix);

    lwct_col_mem #(
        .DEPTH(MAX_WINDOW_WIDTH),
        .AW   (AW),
        .DW   (SUM_W)
    ) u_col_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (mem_clr),
        .i_rd_en  (mem_rd_en),
        .i_rd_addr(mem_rd_addr),
        .i_wr_en  (r_p1_vld),
        .i_wr_addr(r_p1_addr),
        .i_wr_data(mem_wr_data),
        .o_rd_data(mem_rd_data)
    );

    lwct_rem_unit #(
        .NUM_W(PW),
        .DEN_W(WW_W),
        .REM_W(AW)
    ) u_rem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_REM_GO),
        .i_num  (r_pos),
        .i_den  (w),
        .o_done (rem_done),
        .o_rem  (rem_val)
    );

    always_comb begin
        c_center = SW'(r_center);
        c_half   = SW'(half);
        c_l      = c_center - c_half + SW'(r_first);
        c_r      = c_center - c_half + SW'(r_last);
        c_s      = c_l + c_r;
        n_mid    = c_center;
        if (r_found) begin
            n_mid = (c_s >= 0) ? (c_s >>> 1) : -SW'(1);
        end
        if (c_l < 0) begin
            n_left = '0;
        end else if (c_l > C_FW_MAX) begin
            n_left = C_FW_MAX[9:0];
        end else begin
            n_left = c_l[9:0];
        end
        if (c_r < 0) begin
            n_right = '0;
        end else if (c_r > C_FW_MAX) begin
            n_right = C_FW_MAX[9:0];
        end else begin
            n_right = c_r[9:0];
        end
    end

    always_comb begin
        clamp_hit = 1'b1;
        if (r_mid < C_LO) begin
            clamped = C_LO;
        end else if (r_mid > C_HI) begin
            clamped = C_HI;
        end else begin
            clamped   = r_mid;
            clamp_hit = 1'b0;
        end
        n_center = clamped[9:0];
        c_lnw    = SW'(n_center) - SW'(half);
        n_out.detected           = r_found && !clamp_hit;
        n_out.left_edge_x        = r_left;
        n_out.right_edge_x       = r_right;
        n_out.center_x           = n_center;
        n_out.next_window_left_x = (c_lnw < 0) ? 10'd0 : c_lnw[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_width     <= RST_WIDTH;
            r_home      <= RST_HOME;
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_col       <= '0;
            r_total     <= PW'(int'(f_eff(RST_WIDTH)) * WINDOW_ROWS);
            r_lim       <= CMP_W'((int'(RST_THRESHOLD) + 1) * WINDOW_ROWS);
            r_center    <= RST_HOME;
            r_left      <= '0;
            r_right     <= '0;
            r_p1_vld    <= 1'b0;
            r_scan_idx  <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_THRESHOLD: r_threshold <= pwdata[7:0];
                    REG_WIDTH:     r_width     <= pwdata[7:0];
                    REG_HOME:      r_home      <= pwdata[9:0];
                    default: ;
                endcase
            end
            r_total   <= n_total;
            r_lim     <= n_lim;
            r_p1_vld  <= acc_pix;
            r_cmp_vld <= scan_rd;
            r_out_vld <= (r_state == S_FIN2);
            unique case (r_state)
                S_IDLE: begin
                    if (acc_act) begin
                        r_center <= r_home;
                        r_pos    <= '0;
                        r_col    <= '0;
                    end else if (acc_pix) begin
                        if (win_end) begin
                            r_state    <= S_SCAN;
                            r_pos      <= '0;
                            r_col      <= '0;
                            r_scan_idx <= '0;
                            r_found    <= 1'b0;
                        end else begin
                            r_pos <= n_pos;
                            r_col <= col_last ? '0 : (r_col + AW'(1));
                        end
                    end else if (cfg_wr && (cfg_idx == REG_WIDTH)) begin
                        r_state <= S_REM_GO;
                    end
                end
                S_REM_GO: begin
                    r_state <= S_REM;
                end
                S_REM: begin
                    if (rem_done) begin
                        r_col   <= rem_val;
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (scan_rd) begin
                        r_scan_idx <= r_scan_idx + WW_W'(1);
                    end
                    if (r_cmp_vld && bright) begin
                        r_found <= 1'b1;
                    end
                    if (scan_last) begin
                        r_state <= S_FIN1;
                    end
                end
                S_FIN1: begin
                    if (r_found) begin
                        r_left  <= n_left;
                        r_right <= n_right;
                    end
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_center <= n_center;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_pix) begin
            r_p1_addr <= r_col;
            r_p1_pix  <= i_in.pixel;
        end
        if (scan_rd) begin
            r_cmp_idx <= r_scan_idx[AW-1:0];
        end
        if (r_cmp_vld && bright) begin
            if (!r_found) begin
                r_first <= r_cmp_idx;
            end
            r_last <= r_cmp_idx;
        end
        if (r_state == S_FIN1) begin
            r_mid <= n_mid;
        end
        if (r_state == S_FIN2) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_THRESHOLD: prdata = {24'd0, r_threshold};
            REG_WIDTH:     prdata = {24'd0, r_width};
            REG_HOME:      prdata = {22'd0, r_home};
            default:       prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign busy           = r_state != S_IDLE;
    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    `LWCT_ASSERT_NXT(a_fin_gives_result, i_clk, i_rst_n, r_state == S_FIN2, o_result_valid)
    `LWCT_ASSERT_NXT(a_single_result, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    `LWCT_ASSERT_NXT(a_window_end_scans, i_clk, i_rst_n, acc_pix && win_end, r_state == S_SCAN && r_scan_idx == '0)

endmodule

FILE: sv/lwct_col_mem.sv
// ----------------------------------------------------------------------------
// Lane window center tracker column store
// Synchronous column sum memory with per-entry valid bits, a registered read
// and write-to-read forwarding.
// ----------------------------------------------------------------------------
module lwct_col_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_q;
    logic             r_q_vld;
    logic             r_fwd;
    logic [DW-1:0]    r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_q_vld    <= r_valid[i_rd_addr];
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_q_vld ? r_q : '0);

endmodule

FILE: sv/lwct_rem_unit.sv
// ----------------------------------------------------------------------------
// Lane window center tracker remainder unit
// Restoring remainder, one numerator bit per cycle.
// ----------------------------------------------------------------------------
module lwct_rem_unit #(
    parameter int NUM_W = 11,
    parameter int DEN_W = 8,
    parameter int REM_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [REM_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_act;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_act <= 1'b1;
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_act) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end else begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_act && (r_cnt != '0)) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_act && (r_cnt == '0);
    assign o_rem  = r_rem[REM_W-1:0];

endmodule
